/* rtl/tcsp_pkg.sv */
`timescale 1ns / 1ps
package tcsp_pkg;

  // Coordinate width of directions and support points (signed Q16.16)
  localparam int COORD_WIDTH = 32;
  // Width of radii and offsets, and of the rim-coordinate quotient
  localparam int QUO_WIDTH = 31;
  localparam int SINE_WIDTH = 17;
  localparam int MINLEN_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;
  // Cycles from an accepted request to its result strobe
  localparam int PIPE_DEPTH = COORD_WIDTH + QUO_WIDTH + 6;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOTTOM_RADIUS = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOP_RADIUS    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOTTOM_OFFSET = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOP_OFFSET    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIDE_SINE     = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LENGTH    = 3'd5;

  // Y coordinate selection
  localparam logic [1:0] Y_ZERO   = 2'd0;
  localparam logic [1:0] Y_TOP    = 2'd1;
  localparam logic [1:0] Y_BOTTOM = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } point_t;

  // Signs and magnitudes carried alongside the square roots
  typedef struct packed {
    logic                   nx;
    logic                   ny;
    logic                   nz;
    logic [COORD_WIDTH-1:0] mx;
    logic [COORD_WIDTH-1:0] my;
    logic [COORD_WIDTH-1:0] mz;
  } side_t;

  // Output selection carried alongside the dividers
  typedef struct packed {
    logic       nx;
    logic       nz;
    logic       xz_zero;
    logic [1:0] ysel;
  } tail_t;

  // Apply sign to a magnitude, saturating to the signed coordinate range
  function automatic logic [COORD_WIDTH-1:0] encode(input logic neg,
                                                    input logic [QUO_WIDTH-1:0] mag);
    logic [63:0] m;
    logic [63:0] lim;
    m = 64'(mag);
    lim = (64'd1 << (COORD_WIDTH - 1)) - (neg ? 64'd0 : 64'd1);
    if (m > lim) begin
      m = lim;
    end
    return neg ? COORD_WIDTH'(64'd0 - m) : COORD_WIDTH'(m);
  endfunction

endpackage

/* rtl/tcsp_sqrt.sv */
`timescale 1ns / 1ps
module tcsp_sqrt
  import tcsp_pkg::*;
#(
  parameter int W = COORD_WIDTH
) (
  input  logic           clk,
  input  logic [2*W-1:0] rad,
  output logic [W-1:0]   root
);

  logic [W+1:0]   rem_s  [0:W];
  logic [W-1:0]   root_s [0:W];
  logic [2*W-1:0] rad_s  [0:W];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad;

  // One root bit per stage, radicand consumed two bits at a time
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W+3:0] shifted;
    logic [W+3:0] trial;
    logic         ge;

    always_comb begin
      shifted = {rem_s[k], rad_s[k][2*W-1:2*W-2]};
      trial   = {2'b00, root_s[k], 2'b01};
      ge      = shifted >= trial;
    end

    always_ff @(posedge clk) begin
      rem_s[k+1]  <= ge ? (W+2)'(shifted - trial) : (W+2)'(shifted);
      root_s[k+1] <= {root_s[k][W-2:0], ge};
      rad_s[k+1]  <= {rad_s[k][2*W-3:0], 2'b00};
    end
  end

  assign root = root_s[W];

endmodule

/* rtl/tcsp_div.sv */
`timescale 1ns / 1ps
module tcsp_div
  import tcsp_pkg::*;
#(
  parameter int W = COORD_WIDTH
) (
  input  logic                   clk,
  input  logic [W+QUO_WIDTH-1:0] num,
  input  logic [W-1:0]           den,
  output logic [QUO_WIDTH-1:0]   quo
);

  logic [W-1:0]         rem_s [0:QUO_WIDTH];
  logic [QUO_WIDTH-1:0] low_s [0:QUO_WIDTH];
  logic [W-1:0]         den_s [0:QUO_WIDTH];
  logic [QUO_WIDTH-1:0] quo_s [0:QUO_WIDTH];

  // The quotient fits QUO_WIDTH bits, so the high part already sits below den
  assign rem_s[0] = num[W+QUO_WIDTH-1:QUO_WIDTH];
  assign low_s[0] = num[QUO_WIDTH-1:0];
  assign den_s[0] = den;
  assign quo_s[0] = '0;

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_stage
    logic [W:0] t;
    logic       ge;

    always_comb begin
      t  = {rem_s[k], low_s[k][QUO_WIDTH-1]};
      ge = t >= {1'b0, den_s[k]};
    end

    always_ff @(posedge clk) begin
      rem_s[k+1] <= ge ? W'(t - {1'b0, den_s[k]}) : W'(t);
      low_s[k+1] <= {low_s[k][QUO_WIDTH-2:0], 1'b0};
      den_s[k+1] <= den_s[k];
      quo_s[k+1] <= {quo_s[k][QUO_WIDTH-2:0], ge};
    end
  end

  assign quo = quo_s[QUO_WIDTH];

endmodule

/* rtl/truncated_cone_support_point.sv */
`timescale 1ns / 1ps
// Support point of a truncated cone along its local Y axis, Q16.16. One request
// enters every clock cycle while busy is low, and its result appears on point with
// done high for exactly one cycle. The depth of the pipeline is set by the
// bit-per-stage square-root pipeline (COORD_WIDTH stages) and the bit-per-stage
// divider (31 stages). The receiver cannot stall: results must be taken as they
// come. busy is a registered copy of rst: it is high during reset and in the
// cycle after it. Write configuration only while no request is in flight;
// cfg_ready is always high and writes to unknown indexes are dropped.
module truncated_cone_support_point
  import tcsp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  dir_t                       dir,
  output logic                       done,
  output point_t                     point,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int CW = COORD_WIDTH;

  logic [QUO_WIDTH-1:0]    bottom_radius;
  logic [QUO_WIDTH-1:0]    top_radius;
  logic [QUO_WIDTH-1:0]    bottom_offset;
  logic [QUO_WIDTH-1:0]    top_offset;
  logic [SINE_WIDTH-1:0]   side_sine;
  logic [MINLEN_WIDTH-1:0] min_length;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bottom_radius <= QUO_WIDTH'(65536);
      top_radius    <= QUO_WIDTH'(32768);
      bottom_offset <= QUO_WIDTH'(65536);
      top_offset    <= QUO_WIDTH'(65536);
      side_sine     <= SINE_WIDTH'(46341);
      min_length    <= MINLEN_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOTTOM_RADIUS: bottom_radius <= cfg_data[QUO_WIDTH-1:0];
        REG_TOP_RADIUS:    top_radius    <= cfg_data[QUO_WIDTH-1:0];
        REG_BOTTOM_OFFSET: bottom_offset <= cfg_data[QUO_WIDTH-1:0];
        REG_TOP_OFFSET:    top_offset    <= cfg_data[QUO_WIDTH-1:0];
        REG_SIDE_SINE:     side_sine     <= cfg_data[SINE_WIDTH-1:0];
        REG_MIN_LENGTH:    min_length    <= cfg_data[MINLEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Stage 1: take the request, split into sign and magnitude
  logic  v1;
  side_t sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    sd1.nx <= dir.dir_x[CW-1];
    sd1.ny <= dir.dir_y[CW-1];
    sd1.nz <= dir.dir_z[CW-1];
    sd1.mx <= dir.dir_x[CW-1] ? CW'(-dir.dir_x) : CW'(dir.dir_x);
    sd1.my <= dir.dir_y[CW-1] ? CW'(-dir.dir_y) : CW'(dir.dir_y);
    sd1.mz <= dir.dir_z[CW-1] ? CW'(-dir.dir_z) : CW'(dir.dir_z);
  end

  // Stage 2: squares
  logic          v2;
  side_t         sd2;
  logic [2*CW-1:0] sqx, sqy, sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    sd2 <= sd1;
    sqx <= (2*CW)'(sd1.mx) * (2*CW)'(sd1.mx);
    sqy <= (2*CW)'(sd1.my) * (2*CW)'(sd1.my);
    sqz <= (2*CW)'(sd1.mz) * (2*CW)'(sd1.mz);
  end

  // Stage 3: sums of squares
  logic            v3;
  side_t           sd3;
  logic [2*CW-1:0] sum_xz, sum_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sd3     <= sd2;
    sum_xz  <= sqx + sqz;
    sum_all <= sqx + sqy + sqz;
  end

  // Square roots, with sideband delayed alongside
  logic [CW-1:0] norm, len_xz;

  tcsp_sqrt #(.W(CW)) u_sqrt_all (.clk(clk), .rad(sum_all), .root(norm));
  tcsp_sqrt #(.W(CW)) u_sqrt_xz  (.clk(clk), .rad(sum_xz),  .root(len_xz));

  logic  vq [0:CW];
  side_t sq [0:CW];

  assign vq[0] = v3;
  assign sq[0] = sd3;

  for (genvar k = 0; k < CW; k++) begin : g_sqrt_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k+1] <= 1'b0;
      end else begin
        vq[k+1] <= vq[k];
      end
    end
    always_ff @(posedge clk) begin
      sq[k+1] <= sq[k];
    end
  end

  // Stage A: zero tests and length times sine
  logic              va;
  side_t             sda;
  logic              zero_n, zero_s;
  logic [CW+16:0]    len_sine;
  logic [CW-1:0]     len_xz_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= vq[CW];
    end
  end

  always_ff @(posedge clk) begin
    sda      <= sq[CW];
    zero_n   <= norm <= CW'(min_length);
    zero_s   <= len_xz <= CW'(min_length);
    len_sine <= (CW+17)'(norm) * (CW+17)'(side_sine);
    len_xz_a <= len_xz;
  end

  // Stage B: rim choice and numerators
  logic                  vb;
  tail_t                 tlb;
  logic [CW+QUO_WIDTH-1:0] num_x, num_z;
  logic [CW-1:0]         den_b;
  logic                  upper;
  logic [QUO_WIDTH-1:0]  radius;
  tail_t                 tl_next;

  always_comb begin
    upper   = !sda.ny && ({1'b0, sda.my} > len_sine[CW+16:16]);
    radius  = upper ? top_radius : bottom_radius;
    tl_next.nx      = sda.nx;
    tl_next.nz      = sda.nz;
    tl_next.xz_zero = zero_n || zero_s;
    if (zero_n) begin
      tl_next.ysel = Y_ZERO;
    end else if (zero_s) begin
      tl_next.ysel = sda.ny ? Y_BOTTOM : Y_TOP;
    end else begin
      tl_next.ysel = upper ? Y_TOP : Y_BOTTOM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    tlb   <= tl_next;
    num_x <= (CW+QUO_WIDTH)'(sda.mx) * (CW+QUO_WIDTH)'(radius);
    num_z <= (CW+QUO_WIDTH)'(sda.mz) * (CW+QUO_WIDTH)'(radius);
    den_b <= len_xz_a;
  end

  // Rim coordinates, with output selection delayed alongside
  logic [QUO_WIDTH-1:0] quo_x, quo_z;

  tcsp_div #(.W(CW)) u_div_x (.clk(clk), .num(num_x), .den(den_b), .quo(quo_x));
  tcsp_div #(.W(CW)) u_div_z (.clk(clk), .num(num_z), .den(den_b), .quo(quo_z));

  logic  vd [0:QUO_WIDTH];
  tail_t td [0:QUO_WIDTH];

  assign vd[0] = vb;
  assign td[0] = tlb;

  for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_div_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k+1] <= 1'b0;
      end else begin
        vd[k+1] <= vd[k];
      end
    end
    always_ff @(posedge clk) begin
      td[k+1] <= td[k];
    end
  end

  // Output stage: apply signs and drive the strobe
  tail_t tl_out;
  assign tl_out = td[QUO_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd[QUO_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    point.point_x <= tl_out.xz_zero ? '0 : encode(tl_out.nx, quo_x);
    point.point_z <= tl_out.xz_zero ? '0 : encode(tl_out.nz, quo_z);
    case (tl_out.ysel)
      Y_TOP:    point.point_y <= encode(1'b0, top_offset);
      Y_BOTTOM: point.point_y <= encode(1'b1, bottom_offset);
      default:  point.point_y <= '0;
    endcase
  end

endmodule

/* rtl/tcsp_chk.sv */
`timescale 1ns / 1ps
module tcsp_chk
  import tcsp_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input dir_t                       dir,
  input logic                       done,
  input point_t                     point,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  // Every accepted request yields a result after the fixed depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("result missing after request");

  // No result without a matching request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without request");

  // A zero direction gives the origin
  a_zero_dir: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && dir.dir_x == 0 && dir.dir_y == 0 && dir.dir_z == 0)
    |-> ##PIPE_DEPTH (point.point_x == 0 && point.point_y == 0 && point.point_z == 0))
    else $error("zero direction gave nonzero point");

  // Reset drops any result in flight
  a_reset: assert property (@(posedge clk) rst |=> !done && busy)
    else $error("strobe after reset");

endmodule

bind truncated_cone_support_point tcsp_chk u_tcsp_chk (.*);
